// ===== design/rws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rws_pkg: shared types and constants for the rssi window statistics core
// Level, sum and count types, register indexes and fixed offsets.
// ----------------------------------------------------------------------------
package rws_pkg;

  // signal level in dBm, -138..-11
  typedef logic signed [8:0]  level_t;
  // peak level, floor -127
  typedef logic signed [7:0]  peak_t;
  // running sum of up to 255 levels
  typedef logic signed [16:0] sum_t;
  // sample and hit counts
  typedef logic        [7:0]  count_t;

  // configuration register indexes
  localparam logic REG_WINDOW_LENGTH    = 1'b0;
  localparam logic REG_STRONG_THRESHOLD = 1'b1;

  // reset values of the configuration registers
  localparam count_t WINDOW_LENGTH_RST    = 8'd8;
  localparam level_t STRONG_THRESHOLD_RST = -9'sd90;

  // conversion and window constants
  localparam level_t LEVEL_OFFSET = 9'sd74;
  localparam peak_t  PEAK_FLOOR   = -8'sd127;
  localparam int     MAG_W        = 16;
  localparam int     MAG_STEPS_W  = 4;

endpackage

`default_nettype wire

// ===== design/rssi_window_statistics_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rssi_window_statistics_core: windowed signal-strength statistics
// Converts radio status samples to dBm and reports peak, lowest, mean and
// hit counts once per window.
// ----------------------------------------------------------------------------
// A sample that does not close the window is folded into the statistics,
// and the block is ready again at once, even while an earlier result still
// waits on the output. The sample that closes the window passes these steps:
// it is folded into the statistics, the restoring divider forms the mean
// one quotient bit per cycle, and the result register is loaded (later if
// the previous result has not yet been taken). The window length register
// reads zero as one. Configuration writes are taken in every cycle.
module rssi_window_statistics_core (
  input  wire                   clk,
  input  wire                   rst_n,
  // sample channel
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [7:0]            in_strength_raw,
  input  wire  [7:0]            in_packet_status,
  input  wire  [7:0]            in_rx_count_raw,
  // result channel
  output logic                  out_valid,
  input  wire                   out_ready,
  output rws_pkg::peak_t        out_peak_level,
  output rws_pkg::level_t       out_lowest_level,
  output rws_pkg::level_t       out_mean_level,
  output rws_pkg::count_t       out_carrier_hits,
  output rws_pkg::count_t       out_buffer_hits,
  output rws_pkg::count_t       out_strong_hits,
  // configuration channel
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire                   cfg_index,
  input  wire  [8:0]            cfg_data
);
  import rws_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  // configuration registers
  count_t window_length_r;
  level_t strong_threshold_r;

  // window statistics
  count_t sample_index_r, sample_index_nxt;
  peak_t  running_peak_r, running_peak_nxt;
  level_t running_lowest_r, running_lowest_nxt;
  sum_t   running_sum_r, running_sum_nxt;
  count_t carrier_count_r, carrier_count_nxt;
  count_t buffer_count_r, buffer_count_nxt;
  count_t strong_count_r, strong_count_nxt;

  // sequencer and divider
  logic [1:0]             state_r, state_nxt;
  logic [MAG_STEPS_W-1:0] step_r, step_nxt;
  logic [8:0]             rem_r, rem_nxt;
  logic [MAG_W-1:0]       quo_r, quo_nxt;
  count_t                 divisor_r, divisor_nxt;
  logic                   sum_neg_r, sum_neg_nxt;

  // result register
  logic   out_valid_r, out_valid_nxt;
  peak_t  out_peak_r, out_peak_nxt;
  level_t out_lowest_r, out_lowest_nxt;
  level_t out_mean_r, out_mean_nxt;
  count_t out_carrier_r, out_carrier_nxt;
  count_t out_buffer_r, out_buffer_nxt;
  count_t out_strong_r, out_strong_nxt;

  logic              in_xfer;
  logic              out_xfer;
  logic signed [7:0] raw_s;
  logic signed [7:0] half_s;
  level_t            level;
  count_t            len;
  count_t            taken;
  logic              closes;
  sum_t              sum_abs;
  logic [8:0]        trial;
  logic              trial_ok;
  level_t            quo_level;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_xfer  = out_valid_r & out_ready;
  assign cfg_ready = 1'b1;

  // level conversion: halve toward zero, then subtract the offset
  assign raw_s  = signed'(in_strength_raw);
  assign half_s = (raw_s + signed'({7'd0, raw_s[7]})) >>> 1;
  assign level  = level_t'(half_s) - LEVEL_OFFSET;

  // window close check
  assign len    = (window_length_r == '0) ? count_t'(1) : window_length_r;
  assign taken  = sample_index_r + count_t'(1);
  assign closes = (taken >= len);

  // divider step on the magnitude of the sum
  assign sum_abs   = running_sum_nxt[16] ? -running_sum_nxt : running_sum_nxt;
  assign trial     = {rem_r[7:0], quo_r[MAG_W-1]} - {1'b0, divisor_r};
  assign trial_ok  = ({rem_r[7:0], quo_r[MAG_W-1]} >= {1'b0, divisor_r});
  assign quo_level = sum_neg_r ? -level_t'(quo_r[8:0]) : level_t'(quo_r[8:0]);

  // statistics update
  always_comb begin
    sample_index_nxt   = sample_index_r;
    running_peak_nxt   = running_peak_r;
    running_lowest_nxt = running_lowest_r;
    running_sum_nxt    = running_sum_r;
    carrier_count_nxt  = carrier_count_r;
    buffer_count_nxt   = buffer_count_r;
    strong_count_nxt   = strong_count_r;
    if (in_xfer) begin
      if (level > level_t'(running_peak_r)) begin
        running_peak_nxt = peak_t'(level);
      end
      if ((sample_index_r == '0) || (level < running_lowest_r)) begin
        running_lowest_nxt = level;
      end
      running_sum_nxt = running_sum_r + sum_t'(level);
      if (in_packet_status[6]) begin
        carrier_count_nxt = carrier_count_r + count_t'(1);
      end
      if (in_rx_count_raw[6:0] != 7'd0) begin
        buffer_count_nxt = buffer_count_r + count_t'(1);
      end
      if (level > strong_threshold_r) begin
        strong_count_nxt = strong_count_r + count_t'(1);
      end
      if (!closes) begin
        sample_index_nxt = taken;
      end
    end else if ((state_r == ST_LOAD) && (!out_valid_r || out_ready)) begin
      sample_index_nxt   = '0;
      running_peak_nxt   = PEAK_FLOOR;
      running_lowest_nxt = '0;
      running_sum_nxt    = '0;
      carrier_count_nxt  = '0;
      buffer_count_nxt   = '0;
      strong_count_nxt   = '0;
    end
  end

  // sequencer, divider and result register
  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    divisor_nxt     = divisor_r;
    sum_neg_nxt     = sum_neg_r;
    out_valid_nxt   = out_valid_r & ~out_xfer;
    out_peak_nxt    = out_peak_r;
    out_lowest_nxt  = out_lowest_r;
    out_mean_nxt    = out_mean_r;
    out_carrier_nxt = out_carrier_r;
    out_buffer_nxt  = out_buffer_r;
    out_strong_nxt  = out_strong_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && closes) begin
          state_nxt   = ST_DIV;
          step_nxt    = '0;
          rem_nxt     = '0;
          quo_nxt     = sum_abs[MAG_W-1:0];
          divisor_nxt = taken;
          sum_neg_nxt = running_sum_nxt[16];
        end
      end
      ST_DIV: begin
        if (trial_ok) begin
          rem_nxt = trial;
        end else begin
          rem_nxt = {rem_r[7:0], quo_r[MAG_W-1]};
        end
        quo_nxt  = {quo_r[MAG_W-2:0], trial_ok};
        step_nxt = step_r + 1'b1;
        if (step_r == {MAG_STEPS_W{1'b1}}) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_peak_nxt    = running_peak_r;
          out_lowest_nxt  = running_lowest_r;
          out_mean_nxt    = quo_level;
          out_carrier_nxt = carrier_count_r;
          out_buffer_nxt  = buffer_count_r;
          out_strong_nxt  = strong_count_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_IDLE;
      out_valid_r        <= 1'b0;
      window_length_r    <= WINDOW_LENGTH_RST;
      strong_threshold_r <= STRONG_THRESHOLD_RST;
      sample_index_r     <= '0;
      running_peak_r     <= PEAK_FLOOR;
      running_lowest_r   <= '0;
      running_sum_r      <= '0;
      carrier_count_r    <= '0;
      buffer_count_r     <= '0;
      strong_count_r     <= '0;
    end else begin
      state_r          <= state_nxt;
      out_valid_r      <= out_valid_nxt;
      sample_index_r   <= sample_index_nxt;
      running_peak_r   <= running_peak_nxt;
      running_lowest_r <= running_lowest_nxt;
      running_sum_r    <= running_sum_nxt;
      carrier_count_r  <= carrier_count_nxt;
      buffer_count_r   <= buffer_count_nxt;
      strong_count_r   <= strong_count_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_WINDOW_LENGTH:    window_length_r    <= cfg_data[7:0];
          REG_STRONG_THRESHOLD: strong_threshold_r <= signed'(cfg_data);
          default:              ;
        endcase
      end
    end
  end

  // divider and result payload
  always_ff @(posedge clk) begin
    step_r        <= step_nxt;
    rem_r         <= rem_nxt;
    quo_r         <= quo_nxt;
    divisor_r     <= divisor_nxt;
    sum_neg_r     <= sum_neg_nxt;
    out_peak_r    <= out_peak_nxt;
    out_lowest_r  <= out_lowest_nxt;
    out_mean_r    <= out_mean_nxt;
    out_carrier_r <= out_carrier_nxt;
    out_buffer_r  <= out_buffer_nxt;
    out_strong_r  <= out_strong_nxt;
  end

  assign out_peak_level   = out_peak_r;
  assign out_lowest_level = out_lowest_r;
  assign out_mean_level   = out_mean_r;
  assign out_carrier_hits = out_carrier_r;
  assign out_buffer_hits  = out_buffer_r;
  assign out_strong_hits  = out_strong_r;

endmodule

`default_nettype wire
